>>> sv/tfs_pkg.sv
// Shared types and constants for the timed feeder sequencer.
`timescale 1ns / 1ps

package tfs_pkg;

    // Configuration register widths and indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_INTERVAL = 3'd0,
        REG_OPEN_HOLD     = 3'd1,
        REG_FEED_HOLD     = 3'd2,
        REG_CLOSE_HOLD    = 3'd3,
        REG_PH_ALARM      = 3'd4
    } t_reg_idx;

    localparam logic [26:0] AUTO_INTERVAL_RST = 27'd10000;
    localparam logic [15:0] OPEN_HOLD_RST     = 16'd500;
    localparam logic [15:0] FEED_HOLD_RST     = 16'd1000;
    localparam logic [15:0] CLOSE_HOLD_RST    = 16'd500;
    localparam logic [9:0]  PH_ALARM_RST      = 10'd511;

    // Saturation limits of the step counters.
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [26:0] SINCE_MAX   = 27'h7FF_FFFF;

    // Gate servo outputs.
    localparam logic [7:0]  SERVO_OPEN_DEG   = 8'd90;
    localparam logic [7:0]  SERVO_CLOSED_DEG = 8'd0;
    localparam logic [11:0] PULSE_CLOSED_US  = 12'd500;
    localparam logic [11:0] PULSE_OPEN_US    = 12'(500 + (90 * 2000) / 180);

    // Feed level: floor(d * 100 / 580) = floor(5d / 29) = (d * 2825) >> 14 for d <= 580.
    localparam logic [14:0] ECHO_FULL_SCALE = 15'd580;
    localparam logic [11:0] LEVEL_RECIP     = 12'd2825;
    localparam int          LEVEL_SHIFT     = 14;

    // Whole seconds: floor((left >> 3) / 125) via reciprocal 2^31 / 125 rounded up.
    localparam logic [24:0] SEC_RECIP  = 25'd17179870;
    localparam int          SEC_SHIFT  = 31;
    // Hours: floor((secs >> 4) / 225) via reciprocal 2^22 / 225 rounded up.
    localparam logic [14:0] HOUR_RECIP = 15'd18642;
    localparam int          HOUR_SHIFT = 22;
    // Minutes: floor((rem >> 2) / 15) via reciprocal 2^14 / 15 rounded up.
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;

    localparam logic [17:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [5:0]  HOURS_MAX     = 6'd31;

    typedef struct packed {
        logic [26:0] auto_interval_ms;
        logic [15:0] open_hold_ms;
        logic [15:0] feed_hold_ms;
        logic [15:0] close_hold_ms;
        logic [9:0]  ph_alarm_level;
    } t_cfg;

    // Per-item status that rides along the output pipeline unchanged.
    typedef struct packed {
        logic [1:0] phase;
        logic       gate_open;
        logic       lamp_on;
        logic       ph_high;
        logic       auto_done;
    } t_flags;

    // Sequencer result handed to the arithmetic pipeline.
    typedef struct packed {
        t_flags      flags;
        logic [9:0]  echo_gap;
        logic [26:0] left_ms;
    } t_stage_a;

    // Record carried through the arithmetic pipeline; fields fill in stage by stage.
    typedef struct packed {
        t_flags      flags;
        logic [6:0]  level;
        logic [17:0] secs;
        logic [5:0]  hours;
        logic [11:0] rem;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_dstage;

endpackage

>>> sv/tfs_if.sv
// Input and result channel interfaces for the timed feeder sequencer.
`timescale 1ns / 1ps

interface tfs_in_if;
    logic        valid;
    logic        ready;
    logic        tick;
    logic        button_down;
    logic [9:0]  ph_sample;
    logic [14:0] echo_us;

    modport source (output valid, tick, button_down, ph_sample, echo_us, input ready);
    modport sink   (input valid, tick, button_down, ph_sample, echo_us, output ready);
endinterface

interface tfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  phase;
    logic [7:0]  servo_angle;
    logic [11:0] servo_pulse_us;
    logic        lamp_on;
    logic        ph_high;
    logic [6:0]  feed_level_pct;
    logic [4:0]  wait_hours;
    logic [5:0]  wait_minutes;
    logic [5:0]  wait_seconds;
    logic        auto_done;

    modport source (output valid, phase, servo_angle, servo_pulse_us, lamp_on, ph_high,
                    feed_level_pct, wait_hours, wait_minutes, wait_seconds, auto_done,
                    input ready);
    modport sink   (input valid, phase, servo_angle, servo_pulse_us, lamp_on, ph_high,
                    feed_level_pct, wait_hours, wait_minutes, wait_seconds, auto_done,
                    output ready);
endinterface

>>> sv/tfs_cfg.sv
// Configuration register file for the timed feeder sequencer.
`timescale 1ns / 1ps

module tfs_cfg import tfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_interval_ms <= AUTO_INTERVAL_RST;
            r_cfg.open_hold_ms     <= OPEN_HOLD_RST;
            r_cfg.feed_hold_ms     <= FEED_HOLD_RST;
            r_cfg.close_hold_ms    <= CLOSE_HOLD_RST;
            r_cfg.ph_alarm_level   <= PH_ALARM_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_AUTO_INTERVAL: r_cfg.auto_interval_ms <= i_cfg_data;
                REG_OPEN_HOLD:     r_cfg.open_hold_ms     <= i_cfg_data[15:0];
                REG_FEED_HOLD:     r_cfg.feed_hold_ms     <= i_cfg_data[15:0];
                REG_CLOSE_HOLD:    r_cfg.close_hold_ms    <= i_cfg_data[15:0];
                REG_PH_ALARM:      r_cfg.ph_alarm_level   <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/tfs_seq.sv
// Phase sequencer with step counters and the first pipeline register.
`timescale 1ns / 1ps

module tfs_seq import tfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    tfs_in_if.sink        i_feed,
    output t_stage_a      o_a,
    output logic          o_a_valid,
    input  logic          i_a_ready
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_OPENING = 2'd1,
        PH_FEEDING = 2'd2,
        PH_CLOSING = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_auto, n_auto;
    logic        r_gate, n_gate;
    logic [15:0] r_elapsed, n_elapsed;
    logic [26:0] r_since, n_since;
    logic        n_done;
    t_stage_a    r_a, n_a;
    logic        r_a_valid;
    logic        w_accept;

    assign i_feed.ready = !r_a_valid || i_a_ready;
    assign w_accept     = i_feed.valid && i_feed.ready;

    always_comb begin
        n_phase   = r_phase;
        n_auto    = r_auto;
        n_gate    = r_gate;
        n_elapsed = r_elapsed;
        n_since   = r_since;
        n_done    = 1'b0;

        if (i_feed.tick) begin
            if (r_elapsed != ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 16'd1;
            end
            if (r_since != SINCE_MAX) begin
                n_since = r_since + 27'd1;
            end
        end

        // The button wins over the interval when both would start a cycle.
        if (r_phase == PH_IDLE) begin
            if (i_feed.button_down) begin
                n_phase   = PH_OPENING;
                n_elapsed = '0;
                n_auto    = 1'b0;
                n_gate    = 1'b1;
            end else if (n_since >= i_cfg.auto_interval_ms) begin
                n_phase   = PH_OPENING;
                n_elapsed = '0;
                n_auto    = 1'b1;
                n_gate    = 1'b1;
            end
        end

        // At most one transition per item besides a start; a start can be followed by one more.
        unique case (n_phase)
            PH_IDLE: begin
            end
            PH_OPENING: begin
                if (n_elapsed >= i_cfg.open_hold_ms) begin
                    n_phase   = PH_FEEDING;
                    n_elapsed = '0;
                end
            end
            PH_FEEDING: begin
                if (n_elapsed >= i_cfg.feed_hold_ms) begin
                    n_phase   = PH_CLOSING;
                    n_gate    = 1'b0;
                    n_elapsed = '0;
                end
            end
            PH_CLOSING: begin
                if (n_elapsed >= i_cfg.close_hold_ms) begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                    if (n_auto) begin
                        n_since = '0;
                        n_done  = 1'b1;
                    end
                end
            end
        endcase

        n_a.flags.phase     = n_phase;
        n_a.flags.gate_open = n_gate;
        n_a.flags.lamp_on   = (n_phase != PH_IDLE);
        n_a.flags.ph_high   = (i_feed.ph_sample <= i_cfg.ph_alarm_level);
        n_a.flags.auto_done = n_done;
        n_a.echo_gap        = (i_feed.echo_us >= ECHO_FULL_SCALE) ? 10'd0
                              : 10'(ECHO_FULL_SCALE - i_feed.echo_us);
        // Time left is only shown while idle; zero makes every later time field zero.
        n_a.left_ms         = (n_phase == PH_IDLE && i_cfg.auto_interval_ms > n_since)
                              ? (i_cfg.auto_interval_ms - n_since) : 27'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_auto    <= 1'b0;
            r_gate    <= 1'b0;
            r_elapsed <= '0;
            r_since   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase   <= n_phase;
                r_auto    <= n_auto;
                r_gate    <= n_gate;
                r_elapsed <= n_elapsed;
                r_since   <= n_since;
                r_a       <= n_a;
                r_a_valid <= 1'b1;
            end else if (i_a_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    assign o_a       = r_a;
    assign o_a_valid = r_a_valid;

    // The gate is open exactly in the opening and feeding phases.
    a_gate_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate == (r_phase == PH_OPENING || r_phase == PH_FEEDING))
        else $error("gate position out of step with phase");

    // A completed automatic cycle always reports the idle phase.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.flags.auto_done) |-> (r_a.flags.phase == PH_IDLE))
        else $error("auto_done outside idle");

    // The end of an automatic cycle restarts the interval count.
    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_done) |=> (r_since == 27'd0 && r_phase == PH_IDLE))
        else $error("interval count not restarted after automatic cycle");

endmodule

>>> sv/tfs_div.sv
// Constant-divider pipeline for feed level and time to next feed.
`timescale 1ns / 1ps

module tfs_div import tfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stage_a      i_a,
    input  logic          i_a_valid,
    output logic          o_a_ready,
    tfs_out_if.source     o_res
);

    t_dstage r_b, r_c, r_d, r_e, r_f;
    t_dstage n_b, n_c, n_d, n_e, n_f;
    logic    r_vb, r_vc, r_vd, r_ve, r_vf;
    logic    w_en_b, w_en_c, w_en_d, w_en_e, w_en_f;

    logic [21:0] w_level_prod;
    logic [48:0] w_sec_prod;
    logic [28:0] w_hour_prod;
    logic [17:0] w_hour_secs;
    logic [20:0] w_min_prod;
    logic [11:0] w_min_secs;

    // A stage loads when it is empty or its content moves on.
    assign w_en_f    = !r_vf || o_res.ready;
    assign w_en_e    = !r_ve || w_en_f;
    assign w_en_d    = !r_vd || w_en_e;
    assign w_en_c    = !r_vc || w_en_d;
    assign w_en_b    = !r_vb || w_en_c;
    assign o_a_ready = w_en_b;

    always_comb begin
        // Stage B: feed level and whole seconds left.
        w_level_prod = 22'(i_a.echo_gap) * 22'(LEVEL_RECIP);
        w_sec_prod   = 49'(i_a.left_ms[26:3]) * 49'(SEC_RECIP);
        n_b          = '0;
        n_b.flags    = i_a.flags;
        n_b.level    = w_level_prod[LEVEL_SHIFT +: 7];
        n_b.secs     = w_sec_prod[SEC_SHIFT +: 18];

        // Stage C: whole hours, before saturation.
        w_hour_prod  = 29'(r_b.secs[17:4]) * 29'(HOUR_RECIP);
        n_c          = r_b;
        n_c.hours    = w_hour_prod[HOUR_SHIFT +: 6];

        // Stage D: seconds within the hour, and the hour count clipped to 31.
        w_hour_secs  = 18'(r_c.hours) * SECS_PER_HOUR;
        n_d          = r_c;
        n_d.rem      = 12'(r_c.secs - w_hour_secs);
        n_d.hours    = (r_c.hours > HOURS_MAX) ? HOURS_MAX : r_c.hours;

        // Stage E: whole minutes.
        w_min_prod   = 21'(r_d.rem[11:2]) * 21'(MIN_RECIP);
        n_e          = r_d;
        n_e.minutes  = w_min_prod[MIN_SHIFT +: 6];

        // Stage F: seconds within the minute.
        w_min_secs   = 12'(r_e.minutes) * SECS_PER_MIN;
        n_f          = r_e;
        n_f.seconds  = 6'(r_e.rem - w_min_secs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else begin
            if (w_en_b) r_vb <= i_a_valid;
            if (w_en_c) r_vc <= r_vb;
            if (w_en_d) r_vd <= r_vc;
            if (w_en_e) r_ve <= r_vd;
            if (w_en_f) r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) r_b <= n_b;
        if (w_en_c) r_c <= n_c;
        if (w_en_d) r_d <= n_d;
        if (w_en_e) r_e <= n_e;
        if (w_en_f) r_f <= n_f;
    end

    assign o_res.valid          = r_vf;
    assign o_res.phase          = r_f.flags.phase;
    assign o_res.servo_angle    = r_f.flags.gate_open ? SERVO_OPEN_DEG : SERVO_CLOSED_DEG;
    assign o_res.servo_pulse_us = r_f.flags.gate_open ? PULSE_OPEN_US : PULSE_CLOSED_US;
    assign o_res.lamp_on        = r_f.flags.lamp_on;
    assign o_res.ph_high        = r_f.flags.ph_high;
    assign o_res.feed_level_pct = r_f.level;
    assign o_res.wait_hours     = r_f.hours[4:0];
    assign o_res.wait_minutes   = r_f.minutes;
    assign o_res.wait_seconds   = r_f.seconds;
    assign o_res.auto_done      = r_f.flags.auto_done;

    // The reciprocal steps must leave proper remainders.
    a_mins_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vf |-> (r_f.minutes < 6'd60 && r_f.seconds < 6'd60 && r_f.rem < 12'd3600))
        else $error("time split out of range");

    // No time to next feed is shown during a cycle.
    a_busy_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vf && r_f.flags.lamp_on) |->
        (r_f.hours == 6'd0 && r_f.minutes == 6'd0 && r_f.seconds == 6'd0))
        else $error("wait time shown while a cycle runs");

    // The feed level never exceeds full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (r_b.level <= 7'd100))
        else $error("feed level above 100 percent");

endmodule

>>> sv/timed_feeder_sequencer.sv
// Top level of the timed feeder sequencer: config registers, sequencer, divider pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// i_feed    in         valid / ready        tick, button_down, ph_sample, echo_us
// o_res     out        valid / ready        phase, servo, lamp, pH alarm, level, wait time
// i_cfg_*   in         write enable only    register index and data
//
// One input transfer is taken every clock cycle as long as the pipeline can move.
// A result passes from its input transfer into the sequencer register, then through
// the constant-reciprocal stages B to E and into the result register, stage F. These
// stages split the time left into hours, minutes and seconds and scale the echo
// time to a percentage. A stalled result stage lets earlier stages keep filling,
// so input transfers continue until all six registers hold results. Reset is
// synchronous and active low; it returns the sequencer to idle, clears both
// counters and restores the register defaults.

module timed_feeder_sequencer import tfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tfs_in_if.sink                i_feed,
    tfs_out_if.source             o_res
);

    t_cfg     w_cfg;
    t_stage_a w_a;
    logic     w_a_valid;
    logic     w_a_ready;

    // Register file; the user must write it only while idle, which the block itself does not enforce.
    tfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The sequencer updates its state on each input transfer and registers the
    // status and the raw quantities that the divider pipeline needs.
    tfs_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_feed    (i_feed),
        .o_a       (w_a),
        .o_a_valid (w_a_valid),
        .i_a_ready (w_a_ready)
    );

    // Divider pipeline and result register.
    tfs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a       (w_a),
        .i_a_valid (w_a_valid),
        .o_a_ready (w_a_ready),
        .o_res     (o_res)
    );

endmodule
